[design/lcd_command_stream_decoder_unit_assert.svh]
// Assertion macros for the LCD command stream decoder.
`ifndef LCD_COMMAND_STREAM_DECODER_UNIT_ASSERT_SVH
`define LCD_COMMAND_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/lcdcsd_pkg.sv]
// Package: codes, types and helpers of the LCD command stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package lcdcsd_pkg;

  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;

  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 56;

  // stream bytes seen with no frame open
  localparam logic [7:0] BYTE_RESET  = 8'h00;
  localparam logic [7:0] BYTE_FRAME2 = 8'hFF;
  localparam logic [7:0] BYTE_FRAME6 = 8'hFE;

  localparam logic [2:0] FRAME_NONE = 3'd0;
  localparam logic [2:0] FRAME_SHORT = 3'd2;
  localparam logic [2:0] FRAME_LONG = 3'd6;

  // register codes
  localparam logic [7:0] REG_GRAM_WRITE    = 8'h22;
  localparam logic [7:0] REG_ENTRY_MODE    = 8'h03;
  localparam logic [7:0] REG_WIN_BOTTOM    = 8'h50;
  localparam logic [7:0] REG_WIN_TOP       = 8'h51;
  localparam logic [7:0] REG_WIN_RIGHT     = 8'h52;
  localparam logic [7:0] REG_WIN_LEFT      = 8'h53;
  localparam logic [7:0] REG_CURSOR_Y      = 8'h20;
  localparam logic [7:0] REG_CURSOR_X      = 8'h21;

  // entry modes
  localparam logic [15:0] MODE_XINC_YINC = 16'h1008;
  localparam logic [15:0] MODE_YINC_XDEC = 16'h1020;
  localparam logic [15:0] MODE_XDEC_YINC = 16'h1038;
  localparam logic [15:0] MODE_YDEC_XINC = 16'h1010;
  localparam logic [15:0] MODE_XINC_YDEC = 16'h1018;
  localparam logic [15:0] MODE_YINC_XINC = 16'h1000;
  localparam logic [15:0] MODE_XDEC_YDEC = 16'h1028;
  localparam logic [15:0] MODE_YDEC_XDEC = 16'h1030;
  localparam logic [15:0] MODE_RESET     = MODE_YDEC_XDEC;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic known;
    logic x_first;  // x is the fast axis
    logic x_dec;
    logic y_dec;
  } entry_dir_t;

  typedef struct packed {
    logic        wrap;
    logic [15:0] pos;
  } axis_step_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] pixel_color;
    logic        on_screen;
    logic        clear_screen;
    logic        fill_busy;
    logic        byte_refused;
    logic        bad_register;
  } result_t;

  function automatic entry_dir_t decode_mode(input logic [15:0] mode);
    entry_dir_t d;
    d = '0;
    d.known = 1'b1;
    unique case (mode)
      MODE_XINC_YINC: begin d.x_first = 1'b1; d.x_dec = 1'b0; d.y_dec = 1'b0; end
      MODE_YINC_XDEC: begin d.x_first = 1'b0; d.x_dec = 1'b1; d.y_dec = 1'b0; end
      MODE_XDEC_YINC: begin d.x_first = 1'b1; d.x_dec = 1'b1; d.y_dec = 1'b0; end
      MODE_YDEC_XINC: begin d.x_first = 1'b0; d.x_dec = 1'b0; d.y_dec = 1'b1; end
      MODE_XINC_YDEC: begin d.x_first = 1'b1; d.x_dec = 1'b0; d.y_dec = 1'b1; end
      MODE_YINC_XINC: begin d.x_first = 1'b0; d.x_dec = 1'b0; d.y_dec = 1'b0; end
      MODE_XDEC_YDEC: begin d.x_first = 1'b1; d.x_dec = 1'b1; d.y_dec = 1'b1; end
      MODE_YDEC_XDEC: begin d.x_first = 1'b0; d.x_dec = 1'b1; d.y_dec = 1'b1; end
      default:        d.known = 1'b0;
    endcase
    return d;
  endfunction

  // +/-1 with 16-bit wrap, then fold back into [lo, hi] (signed compares)
  function automatic axis_step_t step_axis(input logic [15:0] pos, input logic dec,
                                           input logic [15:0] lo, input logic [15:0] hi);
    axis_step_t r;
    logic [15:0] p;
    p = dec ? pos - 16'd1 : pos + 16'd1;
    r.wrap = 1'b1;
    if ($signed(p) > $signed(hi)) begin
      r.pos = lo;
    end else if ($signed(p) < $signed(lo)) begin
      r.pos = hi;
    end else begin
      r.pos  = p;
      r.wrap = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/lcd_command_stream_decoder_unit.sv]
// Top level: LCD command stream decoder with GRAM window address counter.
// Each result word is registered in the result register, via the skid register when stalled.
// Throughput: one input word per cycle while s_tready is high; set by the combinational decode
//   and cursor update feeding the result register, with a one-word skid that holds one word while the output stalls.
// Reset (rst, synchronous): no frame open, no run pending, full-screen window,
//   cursor at 0/0, entry mode 0x1030, output buffer empty. Frame byte store is not reset.
`timescale 1ns / 1ps
`default_nettype none
module lcd_command_stream_decoder_unit #(
  parameter int SCREEN_WIDTH  = lcdcsd_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = lcdcsd_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [lcdcsd_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] stream_byte
  input  wire logic                            s_tuser,   // [0] command
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [15:0] pixel_x, [31:16] pixel_y, [47:32] pixel_color, [48] on_screen,
  // [49] clear_screen, [50] fill_busy, [51] byte_refused, [52] bad_register, [55:53] zero
  output logic [lcdcsd_pkg::M_DATA_W-1:0]      m_tdata,
  output logic                                 m_tuser    // [0] pixel_valid
);
  import lcdcsd_pkg::*;

  `include "lcd_command_stream_decoder_unit_assert.svh"

  localparam int          PIX_LIMIT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int          PIX_W     = $clog2(PIX_LIMIT + 1);
  localparam logic [31:0] LIMIT32   = 32'(PIX_LIMIT);
  localparam logic [15:0] W_LAST    = 16'(SCREEN_WIDTH - 1);
  localparam logic [15:0] H_LAST    = 16'(SCREEN_HEIGHT - 1);
  localparam logic [15:0] W_S       = 16'(SCREEN_WIDTH);
  localparam logic [15:0] H_S       = 16'(SCREEN_HEIGHT);

  // ---------------- decoder state ----------------
  logic [2:0]       frame_length, frame_length_next;
  logic [2:0]       frame_index, frame_index_next;
  logic [7:0]       frame_bytes [0:5];
  logic [7:0]       register_code, register_code_next;
  logic [15:0]      entry_mode, entry_mode_next;
  logic [15:0]      cursor_x, cursor_x_next;
  logic [15:0]      cursor_y, cursor_y_next;
  logic [15:0]      window_left, window_left_next;
  logic [15:0]      window_right, window_right_next;
  logic [15:0]      window_top, window_top_next;
  logic [15:0]      window_bottom, window_bottom_next;
  logic [PIX_W-1:0] pixels_left, pixels_left_next;
  logic [15:0]      fill_color, fill_color_next;

  // ---------------- output buffer: result register plus skid ----------------
  result_t out_word, skid_word, res;
  logic    skid_valid;

  logic push, out_free;
  logic cmd;
  logic [7:0] sbyte;

  assign cmd      = s_tuser;
  assign sbyte    = s_tdata;
  assign s_tready = !skid_valid;
  assign push     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // ---------------- single-pass decode ----------------
  logic        frame_done, frame_write, emit;
  logic [2:0]  idx_inc;
  logic [15:0] data;
  logic [31:0] count, clamped;
  entry_dir_t  dir;
  axis_step_t  fast_step, slow_step;

  assign idx_inc = frame_index + 3'd1;
  assign dir     = decode_mode(entry_mode);

  // Frame contents; the closing byte arrives this cycle and is taken from the bus.
  always_comb begin
    if (frame_length == FRAME_SHORT) begin
      data  = {sbyte, frame_bytes[0]};
      count = 32'd1;
    end else begin
      data  = {frame_bytes[1], frame_bytes[0]};
      count = {sbyte, frame_bytes[4], frame_bytes[3], frame_bytes[2]};
    end
    clamped = (count > LIMIT32) ? LIMIT32 : count;
  end

  // Cursor advance: fast axis always steps, slow axis only on a fast-axis wrap.
  always_comb begin
    if (dir.x_first) begin
      fast_step = step_axis(cursor_x, dir.x_dec, window_left, window_right);
      slow_step = step_axis(cursor_y, dir.y_dec, window_top, window_bottom);
    end else begin
      fast_step = step_axis(cursor_y, dir.y_dec, window_top, window_bottom);
      slow_step = step_axis(cursor_x, dir.x_dec, window_left, window_right);
    end
  end

  always_comb begin
    frame_length_next  = frame_length;
    frame_index_next   = frame_index;
    register_code_next = register_code;
    entry_mode_next    = entry_mode;
    cursor_x_next      = cursor_x;
    cursor_y_next      = cursor_y;
    window_left_next   = window_left;
    window_right_next  = window_right;
    window_top_next    = window_top;
    window_bottom_next = window_bottom;
    pixels_left_next   = pixels_left;
    fill_color_next    = fill_color;
    frame_done         = 1'b0;
    frame_write        = 1'b0;
    emit               = 1'b0;
    res                = '0;

    priority if (cmd == CMD_STEP) begin
      if (pixels_left != '0) begin
        emit             = 1'b1;
        pixels_left_next = pixels_left - PIX_W'(1);
      end
    end else if (pixels_left != '0) begin
      res.byte_refused = 1'b1;
    end else if (frame_length != FRAME_NONE) begin
      frame_write      = 1'b1;
      frame_index_next = idx_inc;
      frame_done       = (idx_inc >= frame_length);
    end else begin
      frame_index_next = '0;
      priority case (sbyte)
        BYTE_RESET: begin
          window_left_next   = '0;
          window_right_next  = W_LAST;
          window_top_next    = '0;
          window_bottom_next = H_LAST;
          res.clear_screen   = 1'b1;
        end
        BYTE_FRAME2: frame_length_next = FRAME_SHORT;
        BYTE_FRAME6: frame_length_next = FRAME_LONG;
        default:     register_code_next = sbyte;
      endcase
    end

    if (frame_done) begin
      frame_length_next = FRAME_NONE;
      frame_index_next  = '0;
      priority case (register_code)
        REG_GRAM_WRITE: begin
          fill_color_next = data;
          if (clamped != '0) begin
            emit             = 1'b1;
            pixels_left_next = PIX_W'(clamped - 32'd1);
          end
        end
        REG_ENTRY_MODE: entry_mode_next    = data;
        REG_WIN_BOTTOM: window_bottom_next = H_LAST - data;
        REG_WIN_TOP:    window_top_next    = H_LAST - data;
        REG_WIN_RIGHT:  window_right_next  = W_LAST - data;
        REG_WIN_LEFT:   window_left_next   = W_LAST - data;
        REG_CURSOR_Y:   cursor_y_next      = H_LAST - data;
        REG_CURSOR_X:   cursor_x_next      = W_LAST - data;
        default:        res.bad_register   = 1'b1;
      endcase
    end

    if (emit) begin
      res.pixel_valid = 1'b1;
      res.pixel_x     = cursor_x;
      res.pixel_y     = cursor_y;
      res.pixel_color = fill_color_next;
      res.on_screen   = !cursor_x[15] && ($signed(cursor_x) < $signed(W_S)) &&
                        !cursor_y[15] && ($signed(cursor_y) < $signed(H_S));
      // unknown entry mode leaves the cursor in place
      if (dir.known) begin
        if (dir.x_first) begin
          cursor_x_next = fast_step.pos;
          if (fast_step.wrap) cursor_y_next = slow_step.pos;
        end else begin
          cursor_y_next = fast_step.pos;
          if (fast_step.wrap) cursor_x_next = slow_step.pos;
        end
      end
    end

    res.fill_busy = (pixels_left_next != '0);
  end

  // ---------------- state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length  <= FRAME_NONE;
      frame_index   <= '0;
      register_code <= '0;
      entry_mode    <= MODE_RESET;
      cursor_x      <= '0;
      cursor_y      <= '0;
      window_left   <= '0;
      window_right  <= W_LAST;
      window_top    <= '0;
      window_bottom <= H_LAST;
      pixels_left   <= '0;
      fill_color    <= '0;
    end else if (push) begin
      frame_length  <= frame_length_next;
      frame_index   <= frame_index_next;
      register_code <= register_code_next;
      entry_mode    <= entry_mode_next;
      cursor_x      <= cursor_x_next;
      cursor_y      <= cursor_y_next;
      window_left   <= window_left_next;
      window_right  <= window_right_next;
      window_top    <= window_top_next;
      window_bottom <= window_bottom_next;
      pixels_left   <= pixels_left_next;
      fill_color    <= fill_color_next;
    end
  end

  // frame byte store, written before read, no reset
  always_ff @(posedge clk) begin
    if (push && frame_write) begin
      frame_bytes[frame_index] <= sbyte;
    end
  end

  // ---------------- output buffer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      m_tvalid   <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word <= skid_valid ? skid_word : res;
    end else if (push) begin
      skid_word <= res;
    end
  end

  assign m_tuser = out_word.pixel_valid;
  assign m_tdata = {3'b000, out_word.bad_register, out_word.byte_refused,
                    out_word.fill_busy, out_word.clear_screen, out_word.on_screen,
                    out_word.pixel_color, out_word.pixel_y, out_word.pixel_x};

  // ---------------- assertions ----------------
  `LCD_ASSERT_SAME(a_skid_behind_out, skid_valid, m_tvalid, "skid word without result word")
  `LCD_ASSERT_NEXT(a_busy_means_run, push && res.fill_busy, pixels_left != '0, "fill_busy but no run")
  `LCD_ASSERT_SAME(a_frame_index_range, frame_length != FRAME_NONE, frame_index < frame_length, "frame index past frame length")

endmodule
`default_nettype wire
